// ===== rtl/ppt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ppt_pkg;

	localparam int DEPTH = 16;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	localparam int CMD_W    = 2;
	localparam int IP_W     = 32;
	localparam int HANDLE_W = 16;
	localparam int LEN_W    = 11;
	localparam int STATUS_W = 2;
	localparam int OCC_W    = 5;

	typedef enum logic [CMD_W-1:0] {
		CMD_ADD      = 2'd0,
		CMD_RETRIEVE = 2'd1,
		CMD_CLEAN    = 2'd2
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_DONE      = 2'd0,
		STATUS_FULL      = 2'd1,
		STATUS_NOT_FOUND = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADD,
		ST_SEARCH,
		ST_CLEAN,
		ST_POST
	} state_t;

	typedef struct packed {
		logic [IP_W-1:0]     addr;
		logic [HANDLE_W-1:0] handle;
		logic [LEN_W-1:0]    len;
	} slot_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		slot_t            wdata;
		logic [IDX_W-1:0] raddr;
	} mem_req_t;

endpackage

`default_nettype wire

// ===== rtl/ppt_slot_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ppt_slot_mem
	import ppt_pkg::*;
(
	input  wire logic     clk,
	input  wire mem_req_t req,
	output slot_t         rdata_s1
);

	slot_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		rdata_s1 <= mem_q[req.raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/pending_packet_table_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  tdata fields (lowest bit first)
// s_       in         command[1:0] dest_ip[33:2] packet_handle[49:34] packet_len[60:50]
// m_       out        status[1:0] found_handle[17:2] found_len[28:18] occupancy[33:29]
//
// One request at a time. A retrieve or a clean walks the valid slots through the single
// read port of the slot memory, one slot a cycle. The result waits in an output register
// while the next request is taken; a stalled result holds back only the end of the
// following request. Reset empties the table, no clearing pass is needed.

module pending_packet_table_unit
	import ppt_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,   // command, dest_ip, packet_handle, packet_len
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata    // status, found_handle, found_len, occupancy
);

	state_t state_q, state_d;

	logic [CMD_W-1:0]    cmd_in;
	logic [IP_W-1:0]     ip_q;
	logic [HANDLE_W-1:0] handle_q;
	logic [LEN_W-1:0]    len_q;

	logic [CNT_W-1:0] count_q;
	logic [DEPTH-1:0] taken_q;
	logic [CNT_W-1:0] scan_q;
	logic [CNT_W-1:0] wr_q;
	logic             pend_s1;
	logic [IDX_W-1:0] idx_s1;

	logic [STATUS_W-1:0] res_status_q;
	logic [HANDLE_W-1:0] res_handle_q;
	logic [LEN_W-1:0]    res_len_q;

	logic        out_valid_q;
	logic [39:0] out_data_q;

	mem_req_t mem_req;
	slot_t    rdata_s1;

	logic accept, issue, hit, can_post, keep;
	logic add_ok, add_full, found, not_found, clean_end, load_out;

	ppt_slot_mem u_mem (
		.clk      (clk),
		.req      (mem_req),
		.rdata_s1 (rdata_s1)
	);

	assign cmd_in   = s_tdata[1:0];
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign issue    = (scan_q < count_q);
	assign hit      = pend_s1 && !taken_q[idx_s1] && (rdata_s1.addr == ip_q);
	assign keep     = pend_s1 && !taken_q[idx_s1];
	assign can_post = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		mem_req       = '0;
		mem_req.raddr = scan_q[IDX_W-1:0];
		add_ok        = 1'b0;
		add_full      = 1'b0;
		found         = 1'b0;
		not_found     = 1'b0;
		clean_end     = 1'b0;
		load_out      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (cmd_in)
						CMD_ADD:      state_d = ST_ADD;
						CMD_RETRIEVE: state_d = ST_SEARCH;
						CMD_CLEAN:    state_d = ST_CLEAN;
						default:      state_d = ST_POST;
					endcase
				end
			end
			ST_ADD: begin
				state_d = ST_POST;
				if (count_q < CNT_W'(DEPTH)) begin
					add_ok        = 1'b1;
					mem_req.we    = 1'b1;
					mem_req.waddr = count_q[IDX_W-1:0];
					mem_req.wdata = '{addr: ip_q, handle: handle_q, len: len_q};
				end else begin
					add_full = 1'b1;
				end
			end
			ST_SEARCH: begin
				if (hit) begin
					found   = 1'b1;
					state_d = ST_POST;
				end else if (!issue && !pend_s1) begin
					not_found = 1'b1;
					state_d   = ST_POST;
				end
			end
			ST_CLEAN: begin
				if (keep) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = wr_q[IDX_W-1:0];
					mem_req.wdata = rdata_s1;
				end
				if (!issue && !pend_s1) begin
					clean_end = 1'b1;
					state_d   = ST_POST;
				end
			end
			ST_POST: begin
				if (can_post) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			taken_q     <= '0;
			scan_q      <= '0;
			wr_q        <= '0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				scan_q  <= '0;
				wr_q    <= '0;
				pend_s1 <= 1'b0;
			end else if (state_q == ST_SEARCH || state_q == ST_CLEAN) begin
				pend_s1 <= issue && !found;
				if (issue) begin
					scan_q <= scan_q + 1'b1;
				end
			end
			if (state_q == ST_CLEAN && keep) begin
				wr_q <= wr_q + 1'b1;
			end
			if (add_ok) begin
				count_q                       <= count_q + 1'b1;
				taken_q[count_q[IDX_W-1:0]]   <= 1'b0;
			end
			if (found) begin
				taken_q[idx_s1] <= 1'b1;
			end
			if (clean_end) begin
				count_q <= wr_q;
				taken_q <= '0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= scan_q[IDX_W-1:0];
		if (accept) begin
			ip_q         <= s_tdata[33:2];
			handle_q     <= s_tdata[49:34];
			len_q        <= s_tdata[60:50];
			res_status_q <= STATUS_DONE;
			res_handle_q <= '0;
			res_len_q    <= '0;
		end
		if (add_full) begin
			res_status_q <= STATUS_FULL;
		end
		if (not_found) begin
			res_status_q <= STATUS_NOT_FOUND;
		end
		if (found) begin
			res_handle_q <= rdata_s1.handle;
			res_len_q    <= rdata_s1.len;
		end
		if (load_out) begin
			out_data_q <= {6'd0, OCC_W'(count_q), res_len_q, res_handle_q, res_status_q};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

`ifndef NO_ASSERTIONS
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count beyond table depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		clean_end |=> (taken_q == '0))
		else $error("taken marks left after clean");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEARCH && pend_s1) |-> (CNT_W'(idx_s1) < count_q))
		else $error("search read beyond valid entries");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAN) |-> (wr_q <= scan_q))
		else $error("clean write index ahead of read index");

	assert property (@(posedge clk) disable iff (!arst_n)
		add_full |=> $stable(count_q))
		else $error("dropped add changed the entry count");
`endif

endmodule

`default_nettype wire

// ===== bench/tb_pending_packet_table_unit.sv =====
`timescale 1ns / 1ps

module tb_pending_packet_table_unit;
	import ppt_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int RANDOM_REQUESTS = 520;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 40;

	typedef struct packed {
		logic [OCC_W-1:0]    occupancy;
		logic [LEN_W-1:0]    len;
		logic [HANDLE_W-1:0] handle;
		logic [STATUS_W-1:0] status;
	} result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;

	int      held_count;
	slot_t   held_slot [DEPTH];
	bit      held_taken [DEPTH];
	result_t pending_results [$];
	result_t want_result;
	result_t got_result;
	int      errors = 0;
	int      burst_left = 0;
	int      idle_cycles = 0;
	int      rx_cycle = 0;
	logic [7:0] rx_pattern = 8'hff;

	pending_packet_table_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic result_t apply_request(input logic [CMD_W-1:0] cmd,
			input logic [IP_W-1:0] ip, input logic [HANDLE_W-1:0] handle,
			input logic [LEN_W-1:0] len);
		result_t res;
		int      wr;
		bit      hit;
		res = '0;
		res.status = STATUS_DONE;
		hit = 1'b0;
		wr = 0;
		case (cmd)
			CMD_ADD: begin
				if (held_count >= DEPTH) begin
					res.status = STATUS_FULL;
				end else begin
					held_slot[held_count].addr = ip;
					held_slot[held_count].handle = handle;
					held_slot[held_count].len = len;
					held_taken[held_count] = 1'b0;
					held_count++;
				end
			end
			CMD_RETRIEVE: begin
				res.status = STATUS_NOT_FOUND;
				for (int i = 0; i < held_count; i++) begin
					if (!hit && !held_taken[i] && held_slot[i].addr == ip) begin
						hit = 1'b1;
						held_taken[i] = 1'b1;
						res.handle = held_slot[i].handle;
						res.len = held_slot[i].len;
						res.status = STATUS_DONE;
					end
				end
			end
			CMD_CLEAN: begin
				for (int i = 0; i < held_count; i++) begin
					if (!held_taken[i]) begin
						held_slot[wr] = held_slot[i];
						held_taken[wr] = 1'b0;
						wr++;
					end
				end
				for (int i = wr; i < DEPTH; i++) begin
					held_taken[i] = 1'b0;
				end
				held_count = wr;
			end
			default: begin
			end
		endcase
		res.occupancy = OCC_W'(held_count);
		return res;
	endfunction

	function automatic void compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
		end
	endfunction

	task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [IP_W-1:0] ip,
			input logic [HANDLE_W-1:0] handle, input logic [LEN_W-1:0] len);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= {3'b000, len, handle, ip, cmd};
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(apply_request(cmd, ip, handle, len));
	endtask

	always @(posedge clk) begin
		rx_cycle <= rx_cycle + 1;
		if (rx_cycle % 64 == 63) begin
			rx_pattern <= ($urandom_range(0, 3) == 0) ? 8'hff : (8'($urandom) | 8'h01);
		end
		m_tready <= rx_pattern[rx_cycle % 8];
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_result = m_tdata[33:0];
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: result with no request outstanding, expected none, got %h",
					$time, m_tdata);
			end else begin
				want_result = pending_results.pop_front();
				compare_field("status", want_result.status, got_result.status);
				compare_field("found_handle", want_result.handle, got_result.handle);
				compare_field("found_len", want_result.len, got_result.len);
				compare_field("occupancy", want_result.occupancy, got_result.occupancy);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
				if (idle_cycles == WATCHDOG_LIMIT) begin
					$display("tb_pending_packet_table_unit: done, errors");
					$finish;
				end
			end
		end
	end

	task automatic test_empty_table();
		send_request(CMD_RETRIEVE, 32'h0000_0000, 16'h0000, 11'h000);
		send_request(CMD_CLEAN, 32'hffff_ffff, 16'hffff, 11'h7ff);
		send_request(CMD_UNUSED, 32'hffff_ffff, 16'hffff, 11'h7ff);
	endtask

	task automatic test_field_extremes();
		send_request(CMD_ADD, 32'h0000_0000, 16'h0000, 11'h000);
		send_request(CMD_ADD, 32'hffff_ffff, 16'hffff, 11'h7ff);
		send_request(CMD_ADD, 32'hffff_ffff, 16'h1234, 11'h2aa);
		send_request(CMD_RETRIEVE, 32'hffff_ffff, 16'h0000, 11'h000);
		send_request(CMD_RETRIEVE, 32'hffff_ffff, 16'h0000, 11'h000);
		send_request(CMD_RETRIEVE, 32'hffff_ffff, 16'h0000, 11'h000);
		send_request(CMD_RETRIEVE, 32'h0000_0000, 16'hffff, 11'h7ff);
	endtask

	// The entry taken from the middle of the full table makes the clean below
	// move every entry behind it down.
	task automatic test_full_table();
		int n;
		n = 0;
		while (held_count < DEPTH) begin
			send_request(CMD_ADD, 32'hc0a8_0100 + n, 16'(16'h0100 + n), 11'(n));
			n++;
		end
		send_request(CMD_ADD, 32'h0a00_0001, 16'hbeef, 11'h555);
		send_request(CMD_RETRIEVE, 32'hc0a8_0105, 16'h0000, 11'h000);
		send_request(CMD_CLEAN, 32'h0000_0000, 16'h0000, 11'h000);
		send_request(CMD_CLEAN, 32'h0000_0000, 16'h0000, 11'h000);
	endtask

	task automatic test_random_traffic();
		int               sent;
		int               pick;
		bit               filling;
		logic [IP_W-1:0]  pool [6];
		logic [IP_W-1:0]  ip;
		logic [CMD_W-1:0] cmd;
		sent = 0;
		filling = 1'b1;
		while (sent < RANDOM_REQUESTS) begin
			if (sent % 40 == 0) begin
				foreach (pool[i]) pool[i] = $urandom;
				filling = $urandom_range(0, 1);
			end
			pick = $urandom_range(0, 99);
			if (pick < 4) begin
				cmd = CMD_UNUSED;
			end else if (pick < (filling ? 64 : 40)) begin
				cmd = CMD_ADD;
			end else if (pick < (filling ? 90 : 82)) begin
				cmd = CMD_RETRIEVE;
			end else begin
				cmd = CMD_CLEAN;
			end
			ip = ($urandom_range(0, 9) == 0) ? $urandom : pool[$urandom_range(0, 5)];
			send_request(cmd, ip, 16'($urandom), 11'($urandom));
			sent++;
		end
	endtask

	initial begin
		held_count = 0;
		foreach (held_taken[i]) held_taken[i] = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		test_field_extremes();
		test_full_table();
		test_random_traffic();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("tb_pending_packet_table_unit: done, clean");
		end else begin
			$display("tb_pending_packet_table_unit: done, errors");
		end
		$finish;
	end

endmodule
